### rtl/txcw_pkg.sv
// Shared types and constants for the text console writer.
package txcw_pkg;

  localparam int CELL_W       = 16;
  localparam int CHAR_W       = 8;
  localparam int CURSOR_POS_W = 11;
  localparam int IN_ROW_W     = 5;
  localparam int IN_COL_W     = 7;

  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

endpackage

### rtl/txcw_cell_ram.sv
// Single-port cell memory with registered read data.
module txcw_cell_ram
  import txcw_pkg::*;
#(
  parameter int DEPTH = 3200,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [CELL_W-1:0] wdata,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/text_console_writer_core.sv
// Text console writer: cell grid in one RAM, row ring for scrolling, cursor registers.
// Commands run from idle to the done state, where the result beat is registered; a read
// passes the read state first, a scroll blanks the new bottom row, and clear sweeps the
// full RAM, one cell a cycle. Throughput: one command at a time; the single RAM port sets
// the sweep lengths. Reset (rst_n, synchronous, active low) homes the cursor and runs the
// same clearing pass before the first beat is accepted.
module text_console_writer_core
  import txcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_cmd,
  input  logic [CHAR_W-1:0]       in_char_code,
  input  logic [CHAR_W-1:0]       in_attr,
  input  logic [IN_ROW_W-1:0]     in_row,
  input  logic [IN_COL_W-1:0]     in_column,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CURSOR_POS_W-1:0] out_cursor_pos,
  output logic [CHAR_W-1:0]       out_cell_char,
  output logic [CHAR_W-1:0]       out_cell_attr
);

  // Cells sit at {physical row, column}; rows use a power-of-two stride so no
  // multiplier is needed for addressing.
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  // Physical RAM row that holds logical row 0; advance it to scroll.
  logic [RW-1:0] top_r, top_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;
  logic [CHAR_W-1:0] res_attr_r, res_attr_nxt;

  logic                    out_valid_r;
  logic [CURSOR_POS_W-1:0] out_pos_r;
  logic [CHAR_W-1:0]       out_char_r;
  logic [CHAR_W-1:0]       out_attr_r;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic          accept;
  logic          out_load;
  cmd_t          cmd;
  logic          is_newline;
  logic          at_last_col;
  logic          at_last_row;
  logic          rd_row_ok;
  logic          rd_col_ok;
  logic [RW-1:0] cur_phys;
  logic [RW-1:0] rd_phys;
  logic [RW-1:0] top_inc;
  logic [CW-1:0] col_dec;
  logic [AW-1:0] pos_full;

  // Map a logical row onto the RAM ring.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] lrow);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, lrow};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(in_cmd);

  assign is_newline  = (in_char_code == CHAR_LF) || (in_char_code == CHAR_CR);
  assign at_last_col = (cur_col_r == CW'(COLUMNS - 1));
  assign at_last_row = (cur_row_r == RW'(ROWS - 1));
  assign rd_row_ok   = ({2'b00, in_row} < 7'(ROWS));
  assign rd_col_ok   = ({1'b0, in_column} < 8'(COLUMNS));
  assign cur_phys    = phys_row(top_r, cur_row_r);
  assign rd_phys     = phys_row(top_r, RW'(in_row));
  assign top_inc     = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
  assign col_dec     = cur_col_r - 1'b1;

  // Load the result register once the previous beat has gone.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign pos_full = AW'(cur_row_r) * AW'(COLUMNS) + AW'(cur_col_r);

  always_comb begin
    state_nxt    = state_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    top_nxt      = top_r;
    sweep_nxt    = sweep_r;
    rd_ok_nxt    = rd_ok_r;
    res_char_nxt = res_char_r;
    res_attr_nxt = res_attr_r;
    ram_we       = 1'b0;
    ram_addr     = {cur_phys, cur_col_r};
    ram_wdata    = {in_attr, in_char_code};

    case (state_r)
      S_INIT, S_CLEAR: begin
        // Zero every RAM word, one a cycle.
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(DEPTH - 1)) begin
          sweep_nxt = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_char_nxt = '0;
          res_attr_nxt = '0;
          state_nxt    = S_DONE;
          case (cmd)
            CMD_WRITE: begin
              if (!is_newline) begin
                ram_we      = 1'b1;
                cur_col_nxt = cur_col_r + 1'b1;
              end
              if (is_newline || at_last_col) begin
                cur_col_nxt = '0;
                if (at_last_row) begin
                  state_nxt = S_SCROLL;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end
            end
            CMD_DELETE: begin
              // At column zero nothing changes; the result beat still follows.
              if (cur_col_r != '0) begin
                ram_we      = 1'b1;
                ram_addr    = {cur_phys, col_dec};
                ram_wdata   = {in_attr, {CHAR_W{1'b0}}};
                cur_col_nxt = col_dec;
              end
            end
            CMD_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              top_nxt     = '0;
              sweep_nxt   = '0;
              state_nxt   = S_CLEAR;
            end
            CMD_READ: begin
              rd_ok_nxt = rd_row_ok && rd_col_ok;
              if (rd_row_ok && rd_col_ok) begin
                ram_addr = {rd_phys, CW'(in_column)};
              end
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        res_char_nxt = rd_ok_r ? ram_rdata[CHAR_W-1:0] : '0;
        res_attr_nxt = rd_ok_r ? ram_rdata[CELL_W-1:CHAR_W] : '0;
        state_nxt    = S_DONE;
      end

      S_SCROLL: begin
        // The old top row becomes the new bottom row: blank it, then advance the ring.
        ram_we    = 1'b1;
        ram_addr  = {top_r, sweep_r[CW-1:0]};
        ram_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r[CW-1:0] == CW'(COLUMNS - 1)) begin
          sweep_nxt = '0;
          top_nxt   = top_inc;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      sweep_r     <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      top_r     <= top_nxt;
      sweep_r   <= sweep_nxt;
      rd_ok_r   <= rd_ok_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk) begin
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    if (out_load) begin
      out_pos_r  <= CURSOR_POS_W'(pos_full);
      out_char_r <= res_char_r;
      out_attr_r <= res_attr_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

  txcw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done state");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_col_r} < (CW+1)'(COLUMNS))
    else $error("cursor column beyond last column");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_row_r} < (RW+1)'(ROWS)) && ({1'b0, top_r} < (RW+1)'(ROWS)))
    else $error("cursor row or ring top out of range");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_DONE) |-> !ram_we)
    else $error("RAM written while a result is being formed");

  a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> at_last_row)
    else $error("scroll with cursor off the last row");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for the text console writer core: directed table, then random bursts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import txcw_pkg::*;

  // Grid size under test; the predictor and the instance share it.
  localparam int NCOLS         = 80;
  localparam int NROWS         = 25;
  localparam int RANDOM_CMDS   = 1300;
  // A scroll sweeps one row, so the settle wait is sized from the row width.
  localparam int SETTLE_CYCLES = 2 * NCOLS + 64;

  typedef struct packed {
    logic [CURSOR_POS_W-1:0] pos;
    logic [CHAR_W-1:0]       ch;
    logic [CHAR_W-1:0]       at;
  } console_result_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [CHAR_W-1:0]     ch;
    logic [CHAR_W-1:0]     at;
    logic [IN_ROW_W-1:0]   r;
    logic [IN_COL_W-1:0]   c;
    bit                    known;
    console_result_t       want;
  } directed_step_t;

  localparam int DIRECTED_COUNT = 23;

  // Directed opening. Rows with known set carry the result typed in; the rest go through
  // the predictor. Row and column are junk on some non-read commands to show they are ignored.
  localparam directed_step_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
    // reads straight after reset: whole grid blank, cursor home
    '{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd0,   1'b1, '{11'd0,   8'h00, 8'h00}},
    '{CMD_READ,   8'hFF, 8'hFF, 5'd24, 7'd79,  1'b1, '{11'd0,   8'h00, 8'h00}},
    // reads off the grid return blank, whatever the cell
    '{CMD_READ,   8'h00, 8'h00, 5'd31, 7'd127, 1'b1, '{11'd0,   8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 5'd25, 7'd0,   1'b1, '{11'd0,   8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd80,  1'b1, '{11'd0,   8'h00, 8'h00}},
    // delete with the cursor at column zero changes nothing
    '{CMD_DELETE, 8'hFF, 8'hFF, 5'd31, 7'd127, 1'b1, '{11'd0,   8'h00, 8'h00}},
    '{CMD_WRITE,  8'h41, 8'h1F, 5'd31, 7'd127, 1'b1, '{11'd1,   8'h00, 8'h00}},
    '{CMD_WRITE,  8'hFF, 8'hFF, 5'd0,  7'd0,   1'b1, '{11'd2,   8'h00, 8'h00}},
    '{CMD_WRITE,  8'h00, 8'h00, 5'd21, 7'd85,  1'b1, '{11'd3,   8'h00, 8'h00}},
    // delete steps back and leaves a blank glyph with the new attribute
    '{CMD_DELETE, 8'h5A, 8'hAA, 5'd10, 7'd42,  1'b1, '{11'd2,   8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd2,   1'b1, '{11'd2,   8'h00, 8'hAA}},
    '{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd1,   1'b1, '{11'd2,   8'hFF, 8'hFF}},
    '{CMD_READ,   8'h00, 8'h00, 5'd0,  7'd0,   1'b1, '{11'd2,   8'h41, 8'h1F}},
    // both newline codes: next row, column zero, nothing stored
    '{CMD_WRITE,  CHAR_LF, 8'h55, 5'd3, 7'd3,  1'b1, '{11'd80,  8'h00, 8'h00}},
    '{CMD_WRITE,  CHAR_CR, 8'hAA, 5'd4, 7'd4,  1'b1, '{11'd160, 8'h00, 8'h00}},
    // codes next to the newline ones are ordinary glyphs
    '{CMD_WRITE,  8'h0B, 8'h80, 5'd0,  7'd0,   1'b0, '0},
    '{CMD_WRITE,  8'h0C, 8'h01, 5'd0,  7'd0,   1'b0, '0},
    '{CMD_WRITE,  8'h09, 8'h7F, 5'd0,  7'd0,   1'b0, '0},
    '{CMD_READ,   8'h00, 8'h00, 5'd2,  7'd0,   1'b0, '0},
    '{CMD_READ,   8'h00, 8'h00, 5'd1,  7'd0,   1'b0, '0},
    '{CMD_DELETE, 8'h00, 8'h00, 5'd0,  7'd0,   1'b0, '0},
    // clear homes the cursor and blanks everything
    '{CMD_CLEAR,  8'hFF, 8'hFF, 5'd31, 7'd127, 1'b1, '{11'd0,   8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 5'd2,  7'd0,   1'b1, '{11'd0,   8'h00, 8'h00}}
  };

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_cmd       = CMD_READ;
  logic [CHAR_W-1:0]       in_char_code = '0;
  logic [CHAR_W-1:0]       in_attr      = '0;
  logic [IN_ROW_W-1:0]     in_row       = '0;
  logic [IN_COL_W-1:0]     in_column    = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [CURSOR_POS_W-1:0] out_cursor_pos;
  logic [CHAR_W-1:0]       out_cell_char;
  logic [CHAR_W-1:0]       out_cell_attr;

  // Predictor state: our own copy of the grid and the cursor.
  logic [CELL_W-1:0] grid_cells [NROWS][NCOLS];
  int                cur_row;
  int                cur_col;

  console_result_t   pending_results [$];

  int cmds_sent;
  int beats_checked;
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int n_newline, n_wrap, n_scroll, n_clear, n_del_noop, n_read_oob;

  text_console_writer_core #(
    .COLUMNS(NCOLS),
    .ROWS   (NROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_attr       (in_attr),
    .in_row        (in_row),
    .in_column     (in_column),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr)
  );

  always #5 clk = ~clk;

  // Blank the grid and home the cursor: the state after reset and after a clear.
  function automatic void console_blank();
    for (int r = 0; r < NROWS; r++)
      for (int c = 0; c < NCOLS; c++)
        grid_cells[r][c] = '0;
    cur_row = 0;
    cur_col = 0;
  endfunction

  // Move to column zero of the next row; off the bottom, shift the grid up one row.
  function automatic void console_next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= NROWS) begin
      for (int r = 0; r < NROWS - 1; r++)
        for (int c = 0; c < NCOLS; c++)
          grid_cells[r][c] = grid_cells[r+1][c];
      for (int c = 0; c < NCOLS; c++)
        grid_cells[NROWS-1][c] = '0;
      cur_row = NROWS - 1;
      n_scroll++;
    end
  endfunction

  // Apply one command to the predicted console and return the result beat it should give.
  function automatic console_result_t console_apply(input cmd_t cmd,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [CHAR_W-1:0] at,
                                                    input logic [IN_ROW_W-1:0] r,
                                                    input logic [IN_COL_W-1:0] c);
    console_result_t res;
    res = '0;
    case (cmd)
      CMD_WRITE: begin
        if (ch == CHAR_LF || ch == CHAR_CR) begin
          n_newline++;
          console_next_line();
        end else begin
          grid_cells[cur_row][cur_col] = {at, ch};
          cur_col++;
          if (cur_col >= NCOLS) begin
            n_wrap++;
            console_next_line();
          end
        end
      end
      CMD_DELETE: begin
        if (cur_col > 0) begin
          cur_col--;
          grid_cells[cur_row][cur_col] = {at, 8'h00};
        end else begin
          n_del_noop++;
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        console_blank();
      end
      default: begin
        if (int'(r) < NROWS && int'(c) < NCOLS) begin
          res.ch = grid_cells[r][c][7:0];
          res.at = grid_cells[r][c][15:8];
        end else begin
          n_read_oob++;
        end
      end
    endcase
    res.pos = CURSOR_POS_W'(cur_row * NCOLS + cur_col);
    return res;
  endfunction

  // Any byte but the two newline codes, so that a run of writes really fills a line.
  function automatic logic [CHAR_W-1:0] pick_glyph();
    logic [CHAR_W-1:0] g;
    do g = CHAR_W'($urandom_range(255)); while (g == CHAR_LF || g == CHAR_CR);
    return g;
  endfunction

  // Present one command beat at a falling edge, hold it until taken, then queue its expected result.
  // Called and returns at a falling edge.
  task automatic send_command(input cmd_t cmd,
                              input logic [CHAR_W-1:0] ch,
                              input logic [CHAR_W-1:0] at,
                              input logic [IN_ROW_W-1:0] r,
                              input logic [IN_COL_W-1:0] c,
                              input bit known,
                              input console_result_t want);
    console_result_t pred;
    // Idling profile by progress: receiver sparse first, sender sparse next, then flat out.
    if (cmds_sent < (DIRECTED_COUNT + RANDOM_CMDS) / 3) begin
      send_idle_pct = 28;
      recv_idle_pct = 72;
    end else if (cmds_sent < 2 * (DIRECTED_COUNT + RANDOM_CMDS) / 3) begin
      send_idle_pct = 72;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    // Drop valid at random before the beat, per the sender's idle percentage.
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_char_code <= ch;
    in_attr      <= at;
    in_row       <= r;
    in_column    <= c;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (in_ready !== 1'b1);
    // Commands are taken in order, so predict at the moment of acceptance; the
    // predictor runs on typed rows too so its state stays in step.
    pred = console_apply(cmd, ch, at, r, c);
    pending_results.push_back(known ? want : pred);
    cmds_sent++;
    @(negedge clk);
  endtask

  // Random part: bursts of well-formed activity (long lines that wrap, runs of newlines
  // that push past the bottom row and scroll, reads near the cursor and the bottom row,
  // delete runs) with occasional clears and some fully random noise.
  task automatic run_random_bursts();
    int                  kind;
    int                  n;
    cmd_t                cmd;
    logic [IN_ROW_W-1:0] rr;
    logic [IN_COL_W-1:0] cc;
    while (cmds_sent < DIRECTED_COUNT + RANDOM_CMDS) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // line fill, now and then long enough to run past the last column
        n = ($urandom_range(2) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          send_command(CMD_WRITE, pick_glyph(), CHAR_W'($urandom), IN_ROW_W'($urandom),
                       IN_COL_W'($urandom), 1'b0, '0);
      end else if (kind < 50) begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
          send_command(CMD_WRITE, $urandom_range(1) ? CHAR_LF : CHAR_CR,
                       CHAR_W'($urandom), IN_ROW_W'($urandom), IN_COL_W'($urandom),
                       1'b0, '0);
      end else if (kind < 65) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(7))
            0: begin
              rr = IN_ROW_W'($urandom);
              cc = IN_COL_W'($urandom);
            end
            1: begin
              rr = IN_ROW_W'(cur_row);
              cc = IN_COL_W'($urandom_range(NCOLS - 1));
            end
            2: begin
              rr = IN_ROW_W'(NROWS - 1);
              cc = IN_COL_W'($urandom_range(NCOLS - 1));
            end
            default: begin
              rr = IN_ROW_W'($urandom_range(NROWS - 1));
              cc = IN_COL_W'($urandom_range(NCOLS - 1));
            end
          endcase
          send_command(CMD_READ, CHAR_W'($urandom), CHAR_W'($urandom), rr, cc, 1'b0, '0);
        end
      end else if (kind < 77) begin
        // delete runs often reach column zero and then stick there
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_command(CMD_DELETE, CHAR_W'($urandom), CHAR_W'($urandom),
                       IN_ROW_W'($urandom), IN_COL_W'($urandom), 1'b0, '0);
      end else if (kind < 79) begin
        send_command(CMD_CLEAR, CHAR_W'($urandom), CHAR_W'($urandom),
                     IN_ROW_W'($urandom), IN_COL_W'($urandom), 1'b0, '0);
      end else begin
        // noise: every field random; damp clears so the cursor can still reach the bottom
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          cmd = cmd_t'($urandom_range(3));
          if (cmd == CMD_CLEAR && $urandom_range(3) != 0)
            cmd = CMD_READ;
          send_command(cmd, CHAR_W'($urandom), CHAR_W'($urandom), IN_ROW_W'($urandom),
                       IN_COL_W'($urandom), 1'b0, '0);
        end
      end
    end
  endtask

  // Result side: stall at random per the current profile, changing at the falling edge.
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest outstanding expectation.
  always @(posedge clk) begin
    console_result_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding: cursor_pos %0d char %0h attr %0h",
               out_cursor_pos, out_cell_char, out_cell_attr);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        beats_checked++;
        if (out_cursor_pos !== exp_r.pos) begin
          $error("cursor_pos: expected %0d, got %0d", exp_r.pos, out_cursor_pos);
          errors++;
        end
        if (out_cell_char !== exp_r.ch) begin
          $error("cell_char: expected %02h, got %02h", exp_r.ch, out_cell_char);
          errors++;
        end
        if (out_cell_attr !== exp_r.at) begin
          $error("cell_attr: expected %02h, got %02h", exp_r.at, out_cell_attr);
          errors++;
        end
      end
    end
  end

  // Hard stop: the slowest legal run (every command a full clear with long stalls on
  // both sides, plus the clearing pass after reset) is well under this.
  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    send_idle_pct = 28;
    recv_idle_pct = 72;
    console_blank();
    // Hold reset, then release it on a falling edge. The block then runs its
    // own clearing pass; the first beat simply waits for ready.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_STEPS[i])
      send_command(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].ch, DIRECTED_STEPS[i].at,
                   DIRECTED_STEPS[i].r, DIRECTED_STEPS[i].c, DIRECTED_STEPS[i].known,
                   DIRECTED_STEPS[i].want);
    run_random_bursts();
    in_valid <= 1'b0;

    // Drain, then watch a little longer for any stray beat.
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d commands, checked %0d result beats, %0d mismatches",
             cmds_sent, beats_checked, errors);
    $display(
      "newlines %0d, wraps %0d, scrolls %0d, clears %0d, column-0 deletes %0d, off-grid reads %0d",
      n_newline, n_wrap, n_scroll, n_clear, n_del_noop, n_read_oob);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
